>>> rtl/scan_candidate_table_macros.svh
// Assertion macros shared by the scan candidate table RTL.
`ifndef SCAN_CANDIDATE_TABLE_MACROS_SVH
`define SCAN_CANDIDATE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at each rising edge outside reset.
`define SCT_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("assertion failed: %m");

// Check that a condition never holds at a rising edge outside reset.
`define SCT_NEVER(lbl, clk_i, rstn_i, expr) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(expr)) \
		else $error("forbidden condition: %m");

`else

`define SCT_ASSERT(lbl, clk_i, rstn_i, prop)
`define SCT_NEVER(lbl, clk_i, rstn_i, expr)

`endif

`endif

>>> rtl/sct_pkg.sv
// Types, codes and defaults shared by the scan candidate table RTL.
package sct_pkg;

	localparam int SLOTS_DEFAULT = 24;
	localparam int CFG_W = 20;
	localparam logic [CFG_W-1:0] COOLDOWN_RESET = CFG_W'(15000);
	localparam int KEY_W = 50;
	localparam int SLOT_W = 5;

	localparam logic [1:0] ACT_ADVERT = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_COOLDOWN = 2'd2;
	localparam logic [1:0] ACT_READ = 2'd3;

	localparam logic [2:0] STS_UPDATED = 3'd0;
	localparam logic [2:0] STS_INSERTED = 3'd1;
	localparam logic [2:0] STS_EVICTED = 3'd2;
	localparam logic [2:0] STS_DROPPED = 3'd3;
	localparam logic [2:0] STS_OTHER = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [47:0] address;
		logic [1:0] address_kind;
		logic signed [7:0] signal_strength;
		logic appearance_present;
		logic [15:0] appearance_code;
		logic looks_hid;
		logic [31:0] now_ms;
		logic [SLOT_W-1:0] slot_select;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic hit;
		logic [SLOT_W-1:0] slot_index;
		logic [47:0] entry_address;
		logic [1:0] entry_kind;
		logic signed [7:0] entry_rssi;
		logic [15:0] entry_appearance;
		logic entry_hid;
		logic [31:0] entry_cooldown;
	} rsp_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [47:0] addr;
		logic hid;
		logic [15:0] app;
		logic signed [7:0] rssi;
		logic [31:0] cooldown;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic key_eq;
		logic stale;
		logic clean;
	} eval_t;

endpackage

>>> rtl/sct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sct_ram #(
	parameter int WIDTH = sct_pkg::ENTRY_W,
	parameter int DEPTH = sct_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sct_eval.sv
// Shared entry compare unit: key match, stale cooldown and eviction candidate.
module sct_eval (
	input sct_pkg::entry_t ent,
	input logic [sct_pkg::KEY_W-1:0] key,
	input logic [31:0] now,
	output sct_pkg::eval_t res
);

	always_comb begin
		res.key_eq = ({ent.kind, ent.addr} == key);
		res.stale = (ent.cooldown < now);
		res.clean = !ent.hid && (ent.cooldown == 32'd0);
	end

endmodule

>>> rtl/scan_candidate_table.sv
// Scan candidate table top level: sequencer, valid bits and result register.
//
//  channel   direction  handshake                 payload
//  request   in         req_valid / req_stall     req (sct_pkg::req_t)
//  result    out        rsp_valid / rsp_stall     rsp (sct_pkg::rsp_t)
//  config    in         cfg_we                    cfg_wdata (retry cooldown, ms)
//
// Actions 0 to 2 walk every slot in turn through one compare unit, since the entry RAM
// has a single read port. Action 3 reads only the selected slot.
// Reset clears the valid bits at once and loads a 15000 ms cooldown; no clearing pass.
// A new request is taken only when the previous one has reached the result register;
// a stalled result holds the final step until it drains.
`include "scan_candidate_table_macros.svh"

module scan_candidate_table #(
	parameter int TABLE_SLOTS = sct_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input sct_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output sct_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [sct_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int XW = IDX_W + sct_pkg::SLOT_W;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);
	localparam logic [XW-1:0] SLOTS_X = XW'(TABLE_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	logic [1:0] state_q;
	logic [sct_pkg::CFG_W-1:0] retry_q;
	sct_pkg::req_t req_q;
	logic [31:0] until_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic chk_q;
	logic [IDX_W-1:0] idx_q;
	logic m_found_q;
	logic f_found_q;
	logic e_found_q;
	logic [IDX_W-1:0] m_idx_q;
	logic [IDX_W-1:0] f_idx_q;
	logic [IDX_W-1:0] e_idx_q;
	sct_pkg::entry_t m_ent_q;
	logic rsp_valid_q;
	sct_pkg::rsp_t rsp_q;

	logic accept;
	logic out_free;
	logic fin_go;
	logic [sct_pkg::KEY_W-1:0] key;
	logic [32:0] sum;
	logic [31:0] until_d;
	logic [XW-1:0] sel_x;
	logic sel_ok;
	logic [IDX_W-1:0] sel_idx;
	logic is_adv;
	logic is_clr;
	logic is_cd;
	logic scan_chk;
	logic cur_v;
	logic take_m;
	logic take_f;
	logic take_e;
	logic drop_v;
	logic cd_wr;
	sct_pkg::entry_t cd_ent;

	logic ram_re;
	logic [IDX_W-1:0] ram_raddr;
	sct_pkg::entry_t ram_rdata;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	sct_pkg::entry_t ram_wdata;
	sct_pkg::eval_t ev;

	logic fin_hit;
	logic [2:0] fin_status;
	logic [IDX_W-1:0] fin_idx;
	sct_pkg::entry_t fin_base;
	sct_pkg::entry_t fin_ent;
	sct_pkg::entry_t out_ent;
	logic [XW-1:0] fin_idx_x;
	sct_pkg::rsp_t rsp_d;

	sct_ram #(
		.WIDTH(sct_pkg::ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sct_eval u_eval (
		.ent(ram_rdata),
		.key(key),
		.now(req_q.now_ms),
		.res(ev)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fin_go = (state_q == ST_FIN) && out_free;
	assign key = {req_q.address_kind, req_q.address};

	assign sum = {1'b0, req.now_ms} + 33'(retry_q);
	assign until_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

	assign sel_x = XW'(req_q.slot_select);
	assign sel_ok = (sel_x < SLOTS_X);
	assign sel_idx = sel_x[IDX_W-1:0];

	assign is_adv = (req_q.action == sct_pkg::ACT_ADVERT);
	assign is_clr = (req_q.action == sct_pkg::ACT_CLEAR);
	assign is_cd = (req_q.action == sct_pkg::ACT_COOLDOWN);

	assign scan_chk = (state_q == ST_SCAN) && chk_q;
	assign cur_v = valid_q[idx_q];
	assign take_m = scan_chk && cur_v && ev.key_eq && !m_found_q && (is_adv || is_cd);
	assign take_f = scan_chk && is_adv && !cur_v && !f_found_q;
	assign take_e = scan_chk && is_adv && ev.clean && !e_found_q;
	assign drop_v = scan_chk && is_clr && cur_v && ev.stale;
	assign cd_wr = scan_chk && is_cd && cur_v && ev.key_eq;

	always_comb begin
		cd_ent = ram_rdata;
		cd_ent.cooldown = until_q;
	end

	assign ram_re = ((state_q == ST_SCAN) && (cnt_q < SLOTS_C)) || (state_q == ST_READ);
	assign ram_raddr = (state_q == ST_READ) ? sel_idx : cnt_q[IDX_W-1:0];
	assign ram_we = cd_wr || (fin_go && is_adv && fin_hit);
	assign ram_waddr = cd_wr ? idx_q : fin_idx;
	assign ram_wdata = cd_wr ? cd_ent : fin_ent;

	always_comb begin
		fin_hit = 1'b0;
		fin_status = sct_pkg::STS_OTHER;
		fin_idx = '0;
		fin_base = '0;
		fin_ent = '0;
		out_ent = '0;
		case (req_q.action)
			sct_pkg::ACT_ADVERT: begin
				if (m_found_q) begin
					fin_hit = 1'b1;
					fin_status = sct_pkg::STS_UPDATED;
					fin_idx = m_idx_q;
					fin_base = m_ent_q;
				end else if (f_found_q) begin
					fin_hit = 1'b1;
					fin_status = sct_pkg::STS_INSERTED;
					fin_idx = f_idx_q;
				end else if (req_q.looks_hid && e_found_q) begin
					fin_hit = 1'b1;
					fin_status = sct_pkg::STS_EVICTED;
					fin_idx = e_idx_q;
				end else begin
					fin_status = sct_pkg::STS_DROPPED;
				end
				fin_ent.kind = req_q.address_kind;
				fin_ent.addr = req_q.address;
				fin_ent.rssi = req_q.signal_strength;
				fin_ent.app = req_q.appearance_present ? req_q.appearance_code : fin_base.app;
				fin_ent.hid = fin_base.hid | req_q.looks_hid;
				fin_ent.cooldown = fin_base.cooldown;
				out_ent = fin_hit ? fin_ent : '0;
			end
			sct_pkg::ACT_CLEAR: begin
				fin_hit = 1'b0;
			end
			sct_pkg::ACT_COOLDOWN: begin
				if (m_found_q) begin
					fin_hit = 1'b1;
					fin_idx = m_idx_q;
					out_ent = m_ent_q;
				end
			end
			sct_pkg::ACT_READ: begin
				if (sel_ok && valid_q[sel_idx]) begin
					fin_hit = 1'b1;
					out_ent = ram_rdata;
				end
			end
			default: begin
				fin_hit = 1'b0;
			end
		endcase
	end

	assign fin_idx_x = XW'(fin_idx);

	always_comb begin
		rsp_d.status = fin_status;
		rsp_d.hit = fin_hit;
		rsp_d.slot_index = (req_q.action == sct_pkg::ACT_READ) ? req_q.slot_select
			: fin_idx_x[sct_pkg::SLOT_W-1:0];
		rsp_d.entry_address = out_ent.addr;
		rsp_d.entry_kind = out_ent.kind;
		rsp_d.entry_rssi = out_ent.rssi;
		rsp_d.entry_appearance = out_ent.app;
		rsp_d.entry_hid = out_ent.hid;
		rsp_d.entry_cooldown = out_ent.cooldown;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			retry_q <= sct_pkg::COOLDOWN_RESET;
			valid_q <= '0;
			cnt_q <= '0;
			chk_q <= 1'b0;
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
			e_found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				retry_q <= cfg_wdata;
			end
			if (rsp_valid_q && !rsp_stall && !fin_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.action == sct_pkg::ACT_READ) ? ST_READ : ST_SCAN;
						cnt_q <= '0;
						chk_q <= 1'b0;
						m_found_q <= 1'b0;
						f_found_q <= 1'b0;
						e_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					chk_q <= (cnt_q < SLOTS_C);
					if (cnt_q < SLOTS_C) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (take_m) begin
						m_found_q <= 1'b1;
					end
					if (take_f) begin
						f_found_q <= 1'b1;
					end
					if (take_e) begin
						e_found_q <= 1'b1;
					end
					if (drop_v) begin
						valid_q[idx_q] <= 1'b0;
					end
					if ((cnt_q == SLOTS_C) && !chk_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						if (is_adv && fin_hit) begin
							valid_q[fin_idx] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			until_q <= until_d;
		end
		if (state_q == ST_SCAN) begin
			idx_q <= cnt_q[IDX_W-1:0];
		end
		if (take_m) begin
			m_idx_q <= idx_q;
			m_ent_q <= is_cd ? cd_ent : ram_rdata;
		end
		if (take_f) begin
			f_idx_q <= idx_q;
		end
		if (take_e) begin
			e_idx_q <= idx_q;
		end
		if (fin_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`SCT_ASSERT(a_accept_leaves_idle, clk, arst_n, req_valid && !req_stall |=> state_q != ST_IDLE)
	`SCT_ASSERT(a_rsp_from_fin, clk, arst_n, $rose(rsp_valid) |-> $past(state_q) == ST_FIN)
	`SCT_ASSERT(a_ram_write_phase, clk, arst_n, ram_we |-> state_q == ST_SCAN || state_q == ST_FIN)
	`SCT_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= SLOTS_C)
	`SCT_NEVER(a_read_state_action, clk, arst_n, (state_q == ST_READ) && (req_q.action != sct_pkg::ACT_READ))

endmodule

>>> tb/scan_candidate_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scan candidate table, predicted results against the block.
module scan_candidate_table_tb;
	import sct_pkg::*;

	localparam int SLOTS = SLOTS_DEFAULT;
	localparam int POOL = 36;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 230;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE = SLOTS + 8;

	class scan_table_shadow;
		bit live[SLOTS];
		logic [KEY_W-1:0] key_of[SLOTS];
		logic signed [7:0] rssi_of[SLOTS];
		logic [15:0] app_of[SLOTS];
		bit hid_of[SLOTS];
		logic [31:0] cooldown_of[SLOTS];
		logic [CFG_W-1:0] retry_ms;
		rsp_t due_results[$];
		int outcome[5];
		int live_reads, cooldowns_set, clears, noted, checked, mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				live[i] = 1'b0;
				key_of[i] = '0;
				rssi_of[i] = '0;
				app_of[i] = '0;
				hid_of[i] = 1'b0;
				cooldown_of[i] = '0;
			end
			retry_ms = COOLDOWN_RESET;
		endfunction

		function rsp_t slot_contents(int s, logic [2:0] st);
			rsp_t r;
			r.status = st;
			r.hit = 1'b1;
			r.slot_index = SLOT_W'(s);
			r.entry_address = key_of[s][47:0];
			r.entry_kind = key_of[s][49:48];
			r.entry_rssi = rssi_of[s];
			r.entry_appearance = app_of[s];
			r.entry_hid = hid_of[s];
			r.entry_cooldown = cooldown_of[s];
			return r;
		endfunction

		function int find_key(logic [KEY_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (live[i] && key_of[i] == k)
					return i;
			return -1;
		endfunction

		function void note_request(req_t q);
			rsp_t want;
			logic [KEY_W-1:0] k;
			logic [32:0] sum;
			logic [31:0] until_ms;
			logic [2:0] st;
			int slot;
			int sel;
			want = '0;
			k = {q.address_kind, q.address};
			slot = -1;
			noted++;
			case (q.action)
				ACT_ADVERT: begin
					st = STS_UPDATED;
					slot = find_key(k);
					for (int i = 0; i < SLOTS && slot < 0; i++) begin
						if (!live[i]) begin
							slot = i;
							live[i] = 1'b1;
							key_of[i] = k;
							rssi_of[i] = '0;
							app_of[i] = '0;
							hid_of[i] = 1'b0;
							cooldown_of[i] = '0;
							st = STS_INSERTED;
						end
					end
					for (int i = 0; i < SLOTS && slot < 0 && q.looks_hid; i++) begin
						if (!hid_of[i] && cooldown_of[i] == 0) begin
							slot = i;
							key_of[i] = k;
							rssi_of[i] = '0;
							app_of[i] = '0;
							st = STS_EVICTED;
						end
					end
					if (slot < 0) begin
						want.status = STS_DROPPED;
					end else begin
						rssi_of[slot] = q.signal_strength;
						hid_of[slot] = hid_of[slot] | q.looks_hid;
						if (q.appearance_present)
							app_of[slot] = q.appearance_code;
						want = slot_contents(slot, st);
					end
					outcome[want.status]++;
				end
				ACT_CLEAR: begin
					for (int i = 0; i < SLOTS; i++)
						if (live[i] && cooldown_of[i] < q.now_ms)
							live[i] = 1'b0;
					want.status = STS_OTHER;
					clears++;
				end
				ACT_COOLDOWN: begin
					sum = {1'b0, q.now_ms} + 33'(retry_ms);
					until_ms = sum[32] ? '1 : sum[31:0];
					for (int i = 0; i < SLOTS; i++) begin
						if (live[i] && key_of[i] == k) begin
							cooldown_of[i] = until_ms;
							if (slot < 0)
								slot = i;
						end
					end
					want.status = STS_OTHER;
					if (slot >= 0) begin
						want = slot_contents(slot, STS_OTHER);
						cooldowns_set++;
					end
				end
				default: begin
					sel = int'(q.slot_select);
					want.status = STS_OTHER;
					want.slot_index = q.slot_select;
					if (sel < SLOTS) begin
						if (live[sel]) begin
							want = slot_contents(sel, STS_OTHER);
							live_reads++;
						end
					end
				end
			endcase
			due_results.push_back(want);
		endfunction

		function string describe(rsp_t r);
			return $sformatf("status %0d hit %0d slot %0d addr %h kind %0d rssi %0d app %h hid %0d cd %h",
				r.status, r.hit, r.slot_index, r.entry_address, r.entry_kind, r.entry_rssi,
				r.entry_appearance, r.entry_hid, r.entry_cooldown);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			string diff;
			diff = "";
			checked++;
			if (due_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with nothing outstanding: %s", $time, describe(got));
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) diff = {diff, " status"};
			if (got.hit !== want.hit) diff = {diff, " hit"};
			if (got.slot_index !== want.slot_index) diff = {diff, " slot_index"};
			if (got.entry_address !== want.entry_address) diff = {diff, " entry_address"};
			if (got.entry_kind !== want.entry_kind) diff = {diff, " entry_kind"};
			if (got.entry_rssi !== want.entry_rssi) diff = {diff, " entry_rssi"};
			if (got.entry_appearance !== want.entry_appearance) diff = {diff, " entry_appearance"};
			if (got.entry_hid !== want.entry_hid) diff = {diff, " entry_hid"};
			if (got.entry_cooldown !== want.entry_cooldown) diff = {diff, " entry_cooldown"};
			if (diff != "") begin
				if (mismatches < 10) begin
					$display("%0t: mismatch in%s", $time, diff);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int unsigned send_idle = 35;
	int unsigned recv_idle = 61;
	int quiet_cycles = 0;
	int cooldown_settings = 1;
	logic [KEY_W-1:0] key_pool[POOL];
	logic [31:0] wall_ms = '0;
	scan_table_shadow shadow;

	scan_candidate_table #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			shadow.check_result(rsp);
		rsp_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timed out: no request or result moved for %0d cycles", QUIET_LIMIT);
			$display("** scan_candidate_table: FAILED **");
			$finish;
		end
	end

	task automatic send_request(input req_t q);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		shadow.note_request(q);
	endtask

	task automatic set_retry_cooldown(input logic [CFG_W-1:0] ms);
		req_valid <= 1'b0;
		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.retry_ms = ms;
		cooldown_settings++;
	endtask

	function automatic req_t make_req(logic [1:0] act, logic [1:0] kind, logic [47:0] addr,
		logic [7:0] rssi, logic present, logic [15:0] app, logic hid, logic [31:0] now,
		logic [4:0] sel);
		req_t q;
		q.action = act;
		q.address = addr;
		q.address_kind = kind;
		q.signal_strength = rssi;
		q.appearance_present = present;
		q.appearance_code = app;
		q.looks_hid = hid;
		q.now_ms = now;
		q.slot_select = sel;
		return q;
	endfunction

	function automatic req_t random_request();
		req_t q;
		logic [63:0] bits;
		int unsigned pick;
		bits = {$urandom, $urandom};
		q.address = bits[47:0];
		q.address_kind = 2'($urandom_range(0, 3));
		q.signal_strength = 8'($urandom_range(0, 255));
		q.appearance_present = 1'($urandom_range(0, 1));
		q.appearance_code = 16'($urandom_range(0, 65535));
		q.looks_hid = ($urandom_range(0, 99) < 30);
		q.now_ms = $urandom;
		q.slot_select = 5'($urandom_range(0, 31));
		pick = $urandom_range(0, 199);
		if (pick < 3)
			q.action = ACT_CLEAR;
		else if (pick < 33)
			q.action = ACT_COOLDOWN;
		else if (pick < 73)
			q.action = ACT_READ;
		else
			q.action = ACT_ADVERT;
		if (q.action != ACT_READ && $urandom_range(0, 9) != 0)
			{q.address_kind, q.address} = key_pool[$urandom_range(0, POOL - 1)];
		if (q.action == ACT_READ && $urandom_range(0, 9) != 0)
			q.slot_select = 5'($urandom_range(0, SLOTS - 1));
		if (q.action == ACT_CLEAR || q.action == ACT_COOLDOWN) begin
			case ($urandom_range(0, 9))
				0: q.now_ms = (q.action == ACT_CLEAR) ? '0 :
					32'hFFFF_FFFF - 32'($urandom_range(0, 2000000));
				1: ;
				default: q.now_ms = wall_ms;
			endcase
		end
		return q;
	endfunction

	initial begin
		logic [CFG_W-1:0] setting;
		shadow = new();
		foreach (key_pool[i])
			key_pool[i] = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd0));
		send_request(make_req(ACT_READ, 2'd3, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd31));
		send_request(make_req(ACT_CLEAR, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd0));
		send_request(make_req(ACT_ADVERT, 2'd0, 48'h0, 8'h80, 1'b1, 16'hFFFF, 1'b0, 32'h0,
			5'd0));
		send_request(make_req(ACT_ADVERT, 2'd0, 48'h0, 8'h7F, 1'b0, 16'h1234, 1'b1, 32'h0,
			5'd0));
		send_request(make_req(ACT_ADVERT, 2'd0, 48'h0, 8'h00, 1'b1, 16'h0000, 1'b0, 32'h0,
			5'd0));
		send_request(make_req(ACT_ADVERT, 2'd3, '1, 8'hFF, 1'b0, 16'hFFFF, 1'b1, '1, 5'd31));
		// saturate, then land exactly on the top value
		send_request(make_req(ACT_COOLDOWN, 2'd3, '1, 8'h00, 1'b0, 16'h0, 1'b0, '1, 5'd0));
		send_request(make_req(ACT_COOLDOWN, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0,
			32'hFFFF_FFFF - 32'd15000, 5'd0));
		send_request(make_req(ACT_COOLDOWN, 2'd2, 48'h5555_5555_5555, 8'h00, 1'b0, 16'h0,
			1'b0, 32'd100, 5'd0));
		send_request(make_req(ACT_CLEAR, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd0));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd0));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd1));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd23));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd24));
		send_request(make_req(ACT_ADVERT, 2'd1, 48'hAAAA_AAAA_AAAA, 8'h55, 1'b1, 16'h5A5A,
			1'b0, 32'h0, 5'd0));
		send_request(make_req(ACT_CLEAR, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'd1, 5'd0));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd2));
		send_request(make_req(ACT_COOLDOWN, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'd5,
			5'd0));
		send_request(make_req(ACT_CLEAR, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, '1, 5'd0));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd0));
		send_request(make_req(ACT_READ, 2'd0, 48'h0, 8'h00, 1'b0, 16'h0, 1'b0, 32'h0, 5'd1));

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: setting = '0;
				1, 5: setting = CFG_W'(1000000);
				3: setting = CFG_W'(1);
				default: setting = CFG_W'($urandom_range(0, 1000000));
			endcase
			send_idle = (seg < 2) ? 35 : (seg < 4) ? 61 : 0;
			recv_idle = (seg < 2) ? 61 : (seg < 4) ? 35 : 0;
			set_retry_cooldown(setting);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				send_request(random_request());
				wall_ms = wall_ms + 32'($urandom_range(0, 3000));
			end
		end

		req_valid <= 1'b0;
		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d results for %0d requests over %0d cooldown settings, %0d mismatches.",
			shadow.checked, shadow.noted, cooldown_settings, shadow.mismatches);
		$display("Adverts %0d updated %0d inserted %0d evicted %0d dropped; %0d clears, %0d %s",
			shadow.outcome[STS_UPDATED], shadow.outcome[STS_INSERTED],
			shadow.outcome[STS_EVICTED], shadow.outcome[STS_DROPPED], shadow.clears,
			shadow.cooldowns_set, $sformatf("cooldowns set, %0d live reads.", shadow.live_reads));
		if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
			$display("** scan_candidate_table: PASSED **");
		else
			$display("** scan_candidate_table: FAILED **");
		$finish;
	end

endmodule
